### sv/scsa_pkg.sv
// Shared types, constants and helper functions for the size-class slab allocator.
package scsa_pkg;

    localparam int BLOCK_COUNT = 16;
    localparam int CLASS_COUNT = 16;
    localparam int BLOCK_SHIFT = 12;
    localparam int SLOT_BITS   = BLOCK_SHIFT - 3;
    localparam int BLK_W       = $clog2(BLOCK_COUNT) + 1;
    localparam int SLOT_W      = SLOT_BITS + 1;
    localparam int SLOT_ADDR_W = $clog2(BLOCK_COUNT) + SLOT_BITS;

    localparam logic [BLK_W-1:0]  BLK_NIL   = BLK_W'(BLOCK_COUNT);
    localparam logic [SLOT_W-1:0] SLOT_NIL  = SLOT_W'(1 << SLOT_BITS);
    localparam logic [3:0]        MAX_CLASS = 4'(BLOCK_SHIFT);

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC,
        S_TAKE_FREED,
        S_INIT,
        S_ADD,
        S_ADD_PREV,
        S_SLOT,
        S_POP,
        S_USED,
        S_REMOVE,
        S_FREE_CHK,
        S_FREE_UPD,
        S_RETIRE,
        S_QUERY,
        S_DONE
    } state_t;

    // Round to 8 bytes, then up to the smallest power-of-two class >= 3.
    function automatic logic [3:0] class_of(input logic [11:0] req);
        logic [12:0] sz;
        logic [3:0]  r;
        sz = (13'(req) + 13'd7) & ~13'd7;
        if (sz == 13'd0)
        begin
            sz = 13'd8;
        end
        r = 4'd13;
        for (int c = 13; c >= 3; c--)
        begin
            if ((14'd1 << c) >= 14'(sz))
            begin
                r = 4'(c);
            end
        end
        return r;
    endfunction

    // Class size in bytes, saturated to the field width.
    function automatic logic [11:0] sat_size(input logic [3:0] c);
        return (c >= 4'd12) ? 12'd4095 : (12'd1 << c);
    endfunction

    // Slots per block for a class.
    function automatic logic [SLOT_W-1:0] slot_cap(input logic [3:0] c);
        return SLOT_NIL >> (c - 4'd3);
    endfunction

endpackage

### sv/scsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scsa_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/size_class_slab_allocator_core.sv
// Size-class slab allocator: allocate, free and size query over block and slot lists.
// A result not yet taken holds the core in S_DONE.
// One request in flight; the next is accepted while the last result waits at the output.
// Free-chain pops pass through S_POP for the registered slot-link RAM read.
// Reset (rst_n, async low) empties all class lists and the freed list; no clearing pass.
module size_class_slab_allocator_core (
    input  logic        clk,
    input  logic        rst_n,
    // config: blocks_in_use
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [11:0] request_size, [27:12] offset_in, zero pad
    input  logic [2:0]  s_tuser,   // [1:0] op, [2] is_null
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] offset_out, [27:16] size_bytes, zero pad
    output logic        m_tuser    // [0] status
);

    import scsa_pkg::*;

    localparam int BI_W = BLK_W - 1;

    state_t state_reg, state_next;

    logic [4:0]        blocks_in_use_reg;
    logic [1:0]        op_reg;
    logic              null_reg;
    logic [15:0]       off_reg;
    logic [3:0]        c_reg, c_next;
    logic [BLK_W-1:0]  b_reg, b_next;
    logic [BLK_W-1:0]  n_reg, n_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [BLK_W-1:0]  fresh_reg, fresh_next;
    logic [BLK_W-1:0]  freed_reg, freed_next;
    logic [15:0]       res_off_reg, res_off_next;
    logic [11:0]       res_size_reg, res_size_next;
    logic              res_status_reg, res_status_next;
    logic              m_valid_reg;
    logic [15:0]       m_off_reg;
    logic [11:0]       m_size_reg;
    logic              m_status_reg;

    // per-block tables and class heads
    logic [BLK_W-1:0]  class_heads [CLASS_COUNT];
    logic [BLK_W-1:0]  block_next  [BLOCK_COUNT];
    logic [BLK_W-1:0]  block_prev  [BLOCK_COUNT];
    logic [3:0]        block_class [BLOCK_COUNT];
    logic [SLOT_W-1:0] block_bump  [BLOCK_COUNT];
    logic [SLOT_W-1:0] block_used  [BLOCK_COUNT];
    logic [SLOT_W-1:0] block_sh    [BLOCK_COUNT];

    // table write strobes
    logic              heads_we, nxt_we, prv_we, cls_we, bump_we, used_we, sh_we;
    logic [BLK_W-1:0]  heads_wd, nxt_wd, prv_wd;
    logic [BI_W-1:0]   nxt_wa, prv_wa;
    logic [SLOT_W-1:0] bump_wd, used_wd, sh_wd;

    // slot-link RAM
    logic                   ram_we;
    logic [SLOT_ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [SLOT_W-1:0]      ram_wdata, ram_rdata;

    // reads at the current block and class
    logic [BI_W-1:0]   bi;
    logic [BLK_W-1:0]  bn, bp, head_c;
    logic [3:0]        bcls;
    logic [SLOT_W-1:0] bbump, bused, bsh, cap;
    logic [BLK_W-1:0]  lim;
    logic [SLOT_W:0]   used_inc;
    logic              alloc_op;

    assign bi       = b_reg[BI_W-1:0];
    assign bn       = block_next[bi];
    assign bp       = block_prev[bi];
    assign bcls     = block_class[bi];
    assign bbump    = block_bump[bi];
    assign bused    = block_used[bi];
    assign bsh      = block_sh[bi];
    assign head_c   = class_heads[c_reg];
    assign cap      = slot_cap(c_reg);
    assign lim      = (blocks_in_use_reg > 5'(BLOCK_COUNT)) ? BLK_W'(BLOCK_COUNT)
                                                            : BLK_W'(blocks_in_use_reg);
    assign used_inc = (SLOT_W+1)'(bused) + 1'b1;
    assign alloc_op = (op_reg == OP_ALLOC);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_size_reg, m_off_reg};
    assign m_tuser  = m_status_reg;

    scsa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (BLOCK_COUNT << SLOT_BITS)
    ) u_slot_links (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (s_tuser[1:0])
                        OP_ALLOC: state_next = S_ALLOC;
                        OP_FREE:  state_next = s_tuser[2] ? S_DONE : S_FREE_CHK;
                        OP_QUERY: state_next = S_QUERY;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_ALLOC:
            begin
                if (c_reg > MAX_CLASS)
                    state_next = S_DONE;
                else if (head_c != BLK_NIL)
                    state_next = S_SLOT;
                else if (freed_reg != BLK_NIL)
                    state_next = S_TAKE_FREED;
                else if (fresh_reg < lim)
                    state_next = S_INIT;
                else
                    state_next = S_DONE;
            end
            S_TAKE_FREED: state_next = S_INIT;
            S_INIT:       state_next = S_ADD;
            S_ADD:
            begin
                if (head_c != BLK_NIL)
                    state_next = S_ADD_PREV;
                else
                    state_next = alloc_op ? S_SLOT : S_DONE;
            end
            S_ADD_PREV:   state_next = alloc_op ? S_SLOT : S_DONE;
            S_SLOT:
            begin
                if (bsh < cap)
                    state_next = S_POP;
                else if (bbump < cap)
                    state_next = S_USED;
                else
                    state_next = S_DONE;
            end
            S_POP:        state_next = S_USED;
            S_USED:       state_next = (used_inc >= (SLOT_W+1)'(cap)) ? S_REMOVE : S_DONE;
            S_REMOVE:     state_next = alloc_op ? S_DONE : S_RETIRE;
            S_FREE_CHK:
            begin
                if (b_reg >= fresh_reg || bused == '0)
                    state_next = S_DONE;
                else
                    state_next = S_FREE_UPD;
            end
            S_FREE_UPD:
            begin
                if (slot_reg >= bbump)
                    state_next = S_DONE;
                else if (bused == SLOT_W'(1))
                    state_next = (bused >= cap) ? S_RETIRE : S_REMOVE;
                else if (bused >= cap)
                    state_next = S_ADD;
                else
                    state_next = S_DONE;
            end
            S_RETIRE:     state_next = S_DONE;
            S_QUERY:      state_next = S_DONE;
            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                    state_next = S_IDLE;
            end
            default:      state_next = S_IDLE;
        endcase
    end

    // datapath controls and table writes
    always_comb
    begin
        c_next          = c_reg;
        b_next          = b_reg;
        n_next          = n_reg;
        slot_next       = slot_reg;
        fresh_next      = fresh_reg;
        freed_next      = freed_reg;
        res_off_next    = res_off_reg;
        res_size_next   = res_size_reg;
        res_status_next = res_status_reg;
        heads_we = 1'b0;  heads_wd = BLK_NIL;
        nxt_we   = 1'b0;  nxt_wa   = bi;  nxt_wd = BLK_NIL;
        prv_we   = 1'b0;  prv_wa   = bi;  prv_wd = BLK_NIL;
        cls_we   = 1'b0;
        bump_we  = 1'b0;  bump_wd  = '0;
        used_we  = 1'b0;  used_wd  = '0;
        sh_we    = 1'b0;  sh_wd    = SLOT_NIL;
        ram_we    = 1'b0;
        ram_waddr = {bi, slot_reg[SLOT_BITS-1:0]};
        ram_wdata = bsh;
        ram_raddr = {bi, bsh[SLOT_BITS-1:0]};
        case (state_reg)
            S_IDLE:
            begin
                c_next          = class_of(s_tdata[11:0]);
                b_next          = BLK_W'(s_tdata[27:12] >> BLOCK_SHIFT);
                res_off_next    = '0;
                res_size_next   = '0;
                res_status_next = 1'b0;
            end
            S_ALLOC:
            begin
                if (c_reg > MAX_CLASS)
                begin
                    res_status_next = 1'b1;
                end
                else
                begin
                    res_size_next = sat_size(c_reg);
                    if (head_c != BLK_NIL)
                    begin
                        b_next = head_c;
                    end
                    else if (freed_reg != BLK_NIL)
                    begin
                        b_next = freed_reg;
                    end
                    else if (fresh_reg < lim)
                    begin
                        b_next     = fresh_reg;
                        fresh_next = fresh_reg + 1'b1;
                    end
                    else
                    begin
                        res_status_next = 1'b1;
                    end
                end
            end
            S_TAKE_FREED:
            begin
                freed_next = bn;
            end
            S_INIT:
            begin
                cls_we  = 1'b1;
                bump_we = 1'b1;
                used_we = 1'b1;
                sh_we   = 1'b1;
            end
            // push block on its class list
            S_ADD:
            begin
                nxt_we   = 1'b1;
                nxt_wd   = head_c;
                prv_we   = 1'b1;
                heads_we = 1'b1;
                heads_wd = b_reg;
                n_next   = head_c;
            end
            S_ADD_PREV:
            begin
                prv_we = 1'b1;
                prv_wa = n_reg[BI_W-1:0];
                prv_wd = b_reg;
            end
            // pick a slot: free chain first, then bump
            S_SLOT:
            begin
                if (bsh < cap)
                begin
                    slot_next = bsh;
                end
                else if (bbump < cap)
                begin
                    slot_next = bbump;
                    bump_we   = 1'b1;
                    bump_wd   = bbump + 1'b1;
                end
                else
                begin
                    res_size_next   = '0;
                    res_status_next = 1'b1;
                end
            end
            S_POP:
            begin
                sh_we = 1'b1;
                sh_wd = ram_rdata;
            end
            S_USED:
            begin
                used_we      = 1'b1;
                used_wd      = SLOT_W'(used_inc);
                res_off_next = {bi, 12'd0} | 16'(16'(slot_reg) << c_reg);
            end
            // unlink block from its class list
            S_REMOVE:
            begin
                if (head_c == b_reg)
                begin
                    heads_we = 1'b1;
                    heads_wd = bn;
                    prv_we   = (bn != BLK_NIL);
                    prv_wa   = bn[BI_W-1:0];
                    prv_wd   = BLK_NIL;
                end
                else
                begin
                    nxt_we = (bp != BLK_NIL);
                    nxt_wa = bp[BI_W-1:0];
                    nxt_wd = bn;
                    prv_we = (bn != BLK_NIL);
                    prv_wa = bn[BI_W-1:0];
                    prv_wd = bp;
                end
            end
            S_FREE_CHK:
            begin
                c_next    = bcls;
                slot_next = SLOT_W'(off_reg[BLOCK_SHIFT-1:0] >> bcls);
            end
            // chain slot back on the block's free chain
            S_FREE_UPD:
            begin
                if (slot_reg < bbump)
                begin
                    ram_we  = 1'b1;
                    sh_we   = 1'b1;
                    sh_wd   = slot_reg;
                    used_we = 1'b1;
                    used_wd = bused - 1'b1;
                end
            end
            // empty block goes to the freed list
            S_RETIRE:
            begin
                nxt_we     = 1'b1;
                nxt_wd     = freed_reg;
                bump_we    = 1'b1;
                sh_we      = 1'b1;
                freed_next = b_reg;
            end
            S_QUERY:
            begin
                if (!null_reg && b_reg < fresh_reg)
                begin
                    res_size_next = sat_size(bcls);
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            blocks_in_use_reg <= 5'd16;
            fresh_reg         <= '0;
            freed_reg         <= BLK_NIL;
            m_valid_reg       <= 1'b0;
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                class_heads[i] <= BLK_NIL;
            end
        end
        else
        begin
            state_reg  <= state_next;
            fresh_reg  <= fresh_next;
            freed_reg  <= freed_next;
            if (cfg_wr_en)
            begin
                blocks_in_use_reg <= cfg_wr_data;
            end
            if (heads_we)
            begin
                class_heads[c_reg] <= heads_wd;
            end
            if (state_reg == S_DONE && (!m_valid_reg || m_tready))
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers and block tables
    always_ff @(posedge clk)
    begin
        c_reg          <= c_next;
        b_reg          <= b_next;
        n_reg          <= n_next;
        slot_reg       <= slot_next;
        res_off_reg    <= res_off_next;
        res_size_reg   <= res_size_next;
        res_status_reg <= res_status_next;
        if (state_reg == S_IDLE)
        begin
            op_reg   <= s_tuser[1:0];
            null_reg <= s_tuser[2];
            off_reg  <= s_tdata[27:12];
        end
        if (state_reg == S_DONE && (!m_valid_reg || m_tready))
        begin
            m_off_reg    <= res_off_reg;
            m_size_reg   <= res_size_reg;
            m_status_reg <= res_status_reg;
        end
        if (nxt_we)  block_next[nxt_wa] <= nxt_wd;
        if (prv_we)  block_prev[prv_wa] <= prv_wd;
        if (cls_we)  block_class[bi]    <= c_reg;
        if (bump_we) block_bump[bi]     <= bump_wd;
        if (used_we) block_used[bi]     <= used_wd;
        if (sh_we)   block_sh[bi]       <= sh_wd;
    end

    // fresh index never runs past the block count
    assert property (@(posedge clk) disable iff (!rst_n) fresh_reg <= BLK_W'(BLOCK_COUNT))
        else $error("fresh block index out of range");

    // a slot handed out lies inside its block
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_USED) |-> (slot_reg < cap))
        else $error("slot index beyond block capacity");

    // a failed allocation carries no offset
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_status_reg) |-> (m_off_reg == 16'd0))
        else $error("failed allocation with nonzero offset");

endmodule
